// ===== rtl/otrp_pkg.sv =====
// Package for the ordered two-input relay pulse block.
// Holds the widths, register reset values, register indexes and shared types.
// No dependencies.
package otrp_pkg;

	// widths
	localparam int AGE_W = 17;
	localparam int CFG_W = 16;
	localparam int IDX_W = 2;

	// saturation ceiling of every age counter
	localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

	// register reset values
	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd100;
	localparam logic [CFG_W-1:0] WINDOW_RESET   = 16'd3000;
	localparam logic [CFG_W-1:0] RELAY_RESET    = 16'd1000;

	// register indexes
	localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [IDX_W-1:0] REG_WINDOW   = 2'd1;
	localparam logic [IDX_W-1:0] REG_RELAY    = 2'd2;

	// debounced press pulses of both inputs for one tick
	typedef struct packed {
		logic a;
		logic b;
	} press_t;

	// decision of the arming logic for one tick
	typedef struct packed {
		logic relay_drive;
		logic armed;
	} ctrl_out_t;

	// saturating increment of an age counter
	function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] v);
		logic [AGE_W-1:0] r;
		r = (v == AGE_MAX) ? AGE_MAX : v + 1'b1;
		return r;
	endfunction

endpackage

// ===== rtl/otrp_debounce.sv =====
// Debounce filter for one active-low input, one tick per step.
// Gives the press pulse of the current tick combinationally and commits state on step.
// Depends on otrp_pkg.
module otrp_debounce import otrp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             raw,
	input  logic [CFG_W-1:0] debounce_ticks,
	output logic             press
);

	logic             stable_q;
	logic             last_raw_q;
	logic [AGE_W-1:0] age_q;

	logic [AGE_W-1:0] age_d;
	logic             stable_d;
	logic             take;

	// a raw change restarts the age, otherwise it counts up
	always_comb begin
		age_d    = (raw != last_raw_q) ? '0 : age_inc(age_q);
		take     = (age_d >= {1'b0, debounce_ticks}) && (stable_q != raw);
		stable_d = take ? raw : stable_q;
		press    = take && !raw;
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q   <= 1'b1;
			last_raw_q <= 1'b1;
			age_q      <= '0;
		end else if (step) begin
			stable_q   <= stable_d;
			last_raw_q <= raw;
			age_q      <= age_d;
		end
	end

endmodule

// ===== rtl/otrp_ctrl.sv =====
// Arming window and relay timer for the relay pulse block.
// Takes both press pulses of a tick and commits pending and relay state on step.
// Depends on otrp_pkg.
module otrp_ctrl import otrp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  press_t           press,
	input  logic [CFG_W-1:0] window_ticks,
	input  logic [CFG_W-1:0] relay_on_ticks,
	output ctrl_out_t        result
);

	logic             pending_q;
	logic [AGE_W-1:0] pending_age_q;
	logic             relay_on_q;
	logic [AGE_W-1:0] relay_age_q;

	logic             pending_d;
	logic [AGE_W-1:0] pending_age_d;
	logic             relay_on_d;
	logic [AGE_W-1:0] relay_age_d;

	// one tick of the arm / fire / timeout sequence
	always_comb begin
		pending_d     = pending_q;
		relay_on_d    = relay_on_q;
		pending_age_d = pending_q ? age_inc(pending_age_q) : pending_age_q;
		relay_age_d   = relay_on_q ? age_inc(relay_age_q) : relay_age_q;
		if (!relay_on_q) begin
			if (!pending_d && press.a) begin
				pending_d     = 1'b1;
				pending_age_d = '0;
			end
			if (pending_d && press.b) begin
				if (pending_age_d <= {1'b0, window_ticks}) begin
					relay_on_d  = 1'b1;
					relay_age_d = '0;
				end
				pending_d = 1'b0;
			end
			if (pending_d && (pending_age_d > {1'b0, window_ticks}))
				pending_d = 1'b0;
		end else if (relay_age_d >= {1'b0, relay_on_ticks}) begin
			relay_on_d = 1'b0;
		end
		result.relay_drive = relay_on_d;
		result.armed       = pending_d;
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q     <= 1'b0;
			pending_age_q <= '0;
			relay_on_q    <= 1'b0;
			relay_age_q   <= '0;
		end else if (step) begin
			pending_q     <= pending_d;
			pending_age_q <= pending_age_d;
			relay_on_q    <= relay_on_d;
			relay_age_q   <= relay_age_d;
		end
	end

	// firing always clears the pending state, so both are never set together
	assert property (@(posedge clk) disable iff (!arst_n) !(pending_q && relay_on_q))
		else $error("relay on while still armed");

	// the relay only switches on from a press of B in a stepped tick
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(relay_on_q) |-> $past(step && press.b))
		else $error("relay fired without a press on B");

	// arming only comes from a press of A in a stepped tick
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pending_q) |-> $past(step && press.a))
		else $error("armed without a press on A");

endmodule

// ===== rtl/ordered_two_input_relay_pulse.sv =====
// Top level of the ordered two-input relay pulse block.
// Instantiates two otrp_debounce filters and otrp_ctrl; holds the registers and pipeline.
// Depends on otrp_pkg, otrp_debounce, otrp_ctrl.

// Each input request is one tick carrying the raw active-low levels of inputs A
// and B; each tick gives exactly one result request with the relay level, both
// debounced press pulses and the armed flag. The block takes one request per
// clock cycle: a tick is captured in an input register, and all filter and
// sequence state is updated in a single pass on the way to the result register,
// so a result is presented once its tick moves on into the result register. A stalled
// result holds the tick behind it in the input register, and the input stalls once
// that register is full. The user must write the registers through cfg_we /
// cfg_index / cfg_data only while no tick is in flight; the block does not enforce
// this. Writes apply from the next tick; index 3 is ignored. There is no start-up sweep.
module ordered_two_input_relay_pulse import otrp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// tick requests
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             raw_level_a,
	input  logic             raw_level_b,
	// result requests
	output logic             out_valid,
	input  logic             out_stall,
	output logic             relay_drive,
	output logic             press_a,
	output logic             press_b,
	output logic             armed,
	// register writes
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [CFG_W-1:0] debounce_ticks_q;
	logic [CFG_W-1:0] window_ticks_q;
	logic [CFG_W-1:0] relay_on_ticks_q;

	logic      valid_s1;
	logic      raw_a_s1;
	logic      raw_b_s1;
	logic      in_take;
	logic      advance;
	press_t    press;
	ctrl_out_t ctrl_res;
	logic      out_valid_q;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= DEBOUNCE_RESET;
			window_ticks_q   <= WINDOW_RESET;
			relay_on_ticks_q <= RELAY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_ticks_q <= cfg_data;
				REG_WINDOW:   window_ticks_q   <= cfg_data;
				REG_RELAY:    relay_on_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_take)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			raw_a_s1 <= raw_level_a;
			raw_b_s1 <= raw_level_b;
		end
	end

	// per-tick state update
	otrp_debounce u_deb_a (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.raw            (raw_a_s1),
		.debounce_ticks (debounce_ticks_q),
		.press          (press.a)
	);

	otrp_debounce u_deb_b (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.raw            (raw_b_s1),
		.debounce_ticks (debounce_ticks_q),
		.press          (press.b)
	);

	otrp_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.press          (press),
		.window_ticks   (window_ticks_q),
		.relay_on_ticks (relay_on_ticks_q),
		.result         (ctrl_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			relay_drive <= ctrl_res.relay_drive;
			press_a     <= press.a;
			press_b     <= press.b;
			armed       <= ctrl_res.armed;
		end
	end

	assign out_valid = out_valid_q;

	// the input side only backs up when stage 1 is holding a tick
	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> valid_s1)
		else $error("input stalled with stage 1 empty");

	// a tick that moves on always lands in the result register
	assert property (@(posedge clk) disable iff (!arst_n) advance |=> out_valid_q)
		else $error("tick lost between stage 1 and result");

	// a held tick in stage 1 keeps its levels until it moves on
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(raw_a_s1) && $stable(raw_b_s1)))
		else $error("held tick changed in stage 1");

endmodule

// ===== verif/tb.sv =====
// Testbench for ordered_two_input_relay_pulse: a tick scoreboard class plus stimulus tasks.
// It predicts every result from the raw levels of each tick and checks it field by field.
// Depends on otrp_pkg and the ordered_two_input_relay_pulse RTL.
module tb import otrp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// index with no register behind it
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int LIMIT_CYCLES = 200_000;
	localparam int RANDOM_TICKS = 1400;
	localparam int PHASE_TICKS  = 250;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		logic relay_drive;
		logic press_a;
		logic press_b;
		logic armed;
	} tick_result_t;

	// debounce filters, arming sequence and relay timer, one tick at a time
	class relay_tick_scoreboard;
		bit [CFG_W-1:0] debounce;
		bit [CFG_W-1:0] window;
		bit [CFG_W-1:0] on_ticks;
		bit             stable[2];
		bit             last_raw[2];
		bit [AGE_W-1:0] level_age[2];
		bit             armed_q;
		bit [AGE_W-1:0] arm_age;
		bit             relay_q;
		bit [AGE_W-1:0] on_age;
		tick_result_t   expected_ticks[$];
		int             errors;
		int             checked;
		int             fires;
		int             presses_a;
		int             presses_b;

		function new();
			debounce = DEBOUNCE_RESET;
			window   = WINDOW_RESET;
			on_ticks = RELAY_RESET;
			for (int i = 0; i < 2; i++) begin
				stable[i]    = 1'b1;
				last_raw[i]  = 1'b1;
				level_age[i] = '0;
			end
			armed_q = 1'b0;
			arm_age = '0;
			relay_q = 1'b0;
			on_age  = '0;
		endfunction

		function bit [AGE_W-1:0] sat_inc(bit [AGE_W-1:0] v);
			return (v == {AGE_W{1'b1}}) ? v : v + 1'b1;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_DEBOUNCE: debounce = val;
				REG_WINDOW:   window = val;
				REG_RELAY:    on_ticks = val;
				default: ;
			endcase
		endfunction

		// one filter tick; returns 1 on a fresh debounced press
		function bit filter_step(int ch, bit raw);
			if (raw != last_raw[ch]) begin
				last_raw[ch]  = raw;
				level_age[ch] = '0;
			end else begin
				level_age[ch] = sat_inc(level_age[ch]);
			end
			if (level_age[ch] >= debounce && stable[ch] != last_raw[ch]) begin
				stable[ch] = last_raw[ch];
				return !stable[ch];
			end
			return 1'b0;
		endfunction

		function void note_tick(bit raw_a, bit raw_b);
			tick_result_t r;
			bit pa;
			bit pb;
			if (armed_q)
				arm_age = sat_inc(arm_age);
			if (relay_q)
				on_age = sat_inc(on_age);
			pa = filter_step(0, raw_a);
			pb = filter_step(1, raw_b);
			// presses only matter while the relay is off
			if (!relay_q) begin
				if (!armed_q && pa) begin
					armed_q = 1'b1;
					arm_age = '0;
				end
				if (armed_q && pb) begin
					if (arm_age <= window) begin
						relay_q = 1'b1;
						on_age  = '0;
						fires++;
					end
					armed_q = 1'b0;
				end
				if (armed_q && arm_age > window)
					armed_q = 1'b0;
			end else if (on_age >= on_ticks) begin
				relay_q = 1'b0;
			end
			presses_a += pa;
			presses_b += pb;
			r.relay_drive = relay_q;
			r.press_a     = pa;
			r.press_b     = pb;
			r.armed       = armed_q;
			expected_ticks.push_back(r);
		endfunction

		task report(string msg);
			if (errors < 30)
				$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task cmp_field(string name, logic want, logic got);
			if (got !== want)
				report($sformatf("result %0d %s expected %0b got %b", checked, name, want, got));
		endtask

		task check_tick_result(tick_result_t got);
			tick_result_t want;
			if (expected_ticks.size() == 0) begin
				report($sformatf("result %0d arrived with no tick outstanding", checked));
				return;
			end
			want = expected_ticks.pop_front();
			cmp_field("relay_drive", want.relay_drive, got.relay_drive);
			cmp_field("press_a", want.press_a, got.press_a);
			cmp_field("press_b", want.press_b, got.press_b);
			cmp_field("armed", want.armed, got.armed);
			checked++;
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic             raw_level_a;
	logic             raw_level_b;
	logic             out_valid;
	logic             out_stall;
	logic             relay_drive;
	logic             press_a;
	logic             press_b;
	logic             armed;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	relay_tick_scoreboard relay_sb;
	int  ticks_sent;
	int  burst_left;
	int  cycles;
	int  input_stall_cycles;
	int  settings_used;
	bit  hold_off_req;

	ordered_two_input_relay_pulse dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.raw_level_a(raw_level_a),
		.raw_level_b(raw_level_b),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.relay_drive(relay_drive),
		.press_a    (press_a),
		.press_b    (press_b),
		.armed      (armed),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			relay_sb.check_tick_result({relay_drive, press_a, press_b, armed});
		if (arst_n && in_valid && in_stall)
			input_stall_cycles++;
	end

	// receiver: stall patterns that change every so often, plus one long hold-off
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		out_stall = 1'b0;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= 1'($urandom_range(0, 1));
					default: out_stall <= (mode_left % 3 == 0);
				endcase
			end
		end
	end

	// one tick request, sent in bursts with gaps between them
	task send_tick(bit a, bit b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = (gap == 0) ? $urandom_range(20, 60) : $urandom_range(1, 24);
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		raw_level_a <= a;
		raw_level_b <= b;
		do
			@(posedge clk);
		while (in_stall);
		relay_sb.note_tick(a, b);
		burst_left--;
		ticks_sent++;
	endtask

	task hold(bit a, bit b, int n);
		repeat (n) send_tick(a, b);
	endtask

	// all results in, then the pipeline is left to drain
	task wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (relay_sb.expected_ticks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		relay_sb.write_reg(idx, val);
	endtask

	task set_regs(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] win, logic [CFG_W-1:0] on_t);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_WINDOW, win);
		write_reg(REG_RELAY, on_t);
		settings_used++;
	endtask

	function automatic int cap(int v, int m);
		return (v > m) ? m : v;
	endfunction

	// one A/B sequence, mostly well formed, some broken or pure noise
	task play_sequence();
		int d;
		int lead;
		int gap;
		int choice;
		d = relay_sb.debounce;
		lead = d + 1 + $urandom_range(0, 4);
		choice = $urandom_range(0, 9);
		hold(1, 1, d + 1 + $urandom_range(0, 3));
		// chatter on A, mostly shorter than the filter
		repeat ($urandom_range(0, 2)) begin
			hold(0, 1, $urandom_range(1, (d > 0) ? d : 1));
			hold(1, 1, 1);
		end
		gap = $urandom_range(0, cap(relay_sb.window, 60) + 4);
		case (choice)
			6: hold(0, 0, lead);
			7: begin
				hold(0, 1, lead);
				hold(1, 1, gap);
			end
			8: begin
				hold(1, 0, lead);
				hold(1, 1, $urandom_range(0, 3));
				hold(0, 1, lead);
			end
			9: repeat ($urandom_range(4, 20))
				send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			default: begin
				hold(0, 1, lead);
				if ($urandom_range(0, 3) == 0)
					hold(0, 0, $urandom_range(1, 3));
				hold(1, 1, gap);
				repeat ($urandom_range(0, 1)) begin
					hold(1, 0, $urandom_range(1, (d > 0) ? d : 1));
					hold(1, 1, 1);
				end
				hold(1, 0, d + 1 + $urandom_range(0, 3));
			end
		endcase
		hold(1, 1, cap(relay_sb.on_ticks, 60) + $urandom_range(0, 4));
	endtask

	initial begin
		int random_start;
		int phase_start;
		int phase;
		logic [CFG_W-1:0] deb;
		logic [CFG_W-1:0] win;
		logic [CFG_W-1:0] on_t;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		raw_level_a = 1'b1;
		raw_level_b = 1'b1;
		cfg_we      = 1'b0;
		cfg_index   = REG_DEBOUNCE;
		cfg_data    = '0;
		relay_sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: a few idle ticks on reset values, then short timings
		hold(1, 1, 2);
		wait_idle();
		write_reg(REG_UNUSED, 16'hFFFF);
		set_regs(16'd0, 16'd2, 16'd2);
		hold(1, 0, 1);      // B with nothing armed
		hold(1, 1, 1);
		hold(0, 0, 1);      // A and B together fire
		hold(1, 1, 1);
		hold(0, 1, 1);      // press while the relay is on
		hold(1, 1, 1);
		hold(0, 1, 1);      // arm, then B too late
		hold(1, 1, 2);
		hold(1, 0, 1);
		hold(1, 1, 1);
		hold(0, 1, 1);      // arm, then time out
		hold(1, 1, 3);
		hold(0, 1, 1);      // arm, B inside the window
		hold(1, 0, 1);
		wait_idle();
		// zero window and zero relay time
		set_regs(16'd0, 16'd0, 16'd0);
		hold(1, 1, 1);
		hold(0, 1, 1);
		hold(1, 0, 1);
		hold(0, 0, 1);
		hold(1, 1, 2);
		wait_idle();

		// random phases, each with its own register setting
		random_start = ticks_sent;
		phase = 0;
		while (ticks_sent - random_start < RANDOM_TICKS) begin
			deb = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
			case ($urandom_range(0, 7))
				0: win = 16'hFFFF;
				1: win = 16'd0;
				default: win = 16'($urandom_range(1, 40));
			endcase
			case ($urandom_range(0, 9))
				0: on_t = 16'hFFFF;
				1: on_t = 16'd0;
				default: on_t = 16'($urandom_range(1, 40));
			endcase
			set_regs(deb, win, on_t);
			if (phase == 1)
				hold_off_req = 1'b1;
			phase_start = ticks_sent;
			while (ticks_sent - phase_start < PHASE_TICKS &&
			       ticks_sent - random_start < RANDOM_TICKS)
				play_sequence();
			wait_idle();
			phase++;
		end

		// largest timings: presses far shorter than the filter never register
		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
		hold(0, 1, 40);
		hold(0, 0, 40);
		hold(1, 1, 4);
		wait_idle();
		repeat (10) @(posedge clk);

		$display("Ran %0d ticks under %0d register settings, %0d results checked.",
		         ticks_sent, settings_used, relay_sb.checked);
		$display("Relay fired %0d times; presses A %0d, B %0d; input stalled %0d cycles.",
		         relay_sb.fires, relay_sb.presses_a, relay_sb.presses_b, input_stall_cycles);
		if (relay_sb.errors == 0 && relay_sb.expected_ticks.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
